FILE: src/eit_pkg.sv
package eit_pkg;

  localparam int unsigned CapacityDefault = 128;

  localparam int unsigned KeyWidth    = 16;
  localparam int unsigned MaskWidth   = 32;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned CountOutWidth = 8;

  // error and hang-up bits, always set on a stored mask
  localparam logic [MaskWidth-1:0] ErrBit = 32'h0000_0008;
  localparam logic [MaskWidth-1:0] HupBit = 32'h0000_0010;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_MODIFY = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_BADOP   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SHIFT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [KeyWidth-1:0]  key;
    logic [MaskWidth-1:0] mask;
  } entry_t;

endpackage

FILE: src/event_interest_table.sv
// Event interest table: a packed table of up to CAPACITY descriptor keys, each with a
// 32-bit event mask, kept in one single-port-write, single-port-read memory with a
// registered read. One request is handled at a time and in_stall_o stays high until its
// result has been taken. Every add, delete or modify scans the valid entries up to the
// first match, one read issued per cycle. A delete that hits stops its scan at the entry
// and then moves every later entry down one place, one entry per cycle. The scan and the
// move share the one memory port. After each result the block returns to idle before it
// takes the next request. An invalid op skips the scan and answers in the cycle after it
// is taken. No clearing pass is needed after reset.
module event_interest_table
  import eit_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               op_i,
  input  logic [KeyWidth-1:0]      key_fd_i,
  input  logic [MaskWidth-1:0]     event_mask_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [StatusWidth-1:0]   status_o,
  output logic [CountOutWidth-1:0] entry_count_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  op_e              op_q, op_d;
  logic [KeyWidth-1:0]  key_q, key_d;
  logic [MaskWidth-1:0] mask_q, mask_d;
  status_e          status_q, status_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [IW-1:0]    pend_idx_q, pend_idx_d;
  logic             hit_q, hit_d;
  logic [IW-1:0]    hit_idx_q, hit_idx_d;

  entry_t           mem [CAPACITY];
  entry_t           rd_q;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  entry_t           mem_wdata;

  logic in_txn;
  logic out_txn;
  logic match;
  logic more;
  logic full;

  assign in_txn  = in_valid_i && !in_stall_o;
  assign out_txn = out_valid_o && !out_stall_i;
  assign match   = pend_q && (rd_q.key == key_q);
  assign more    = idx_q < count_q;
  assign full    = count_q == CW'(CAPACITY);

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = state_q == S_OUT;
  assign status_o      = status_q;
  assign entry_count_o = CountOutWidth'(count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_txn) begin
          state_d = (op_e'(op_i) == OP_BAD) ? S_OUT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (match || (!more && !pend_q)) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = (op_q == OP_DELETE && hit_q) ? S_SHIFT : S_OUT;
      end
      S_SHIFT: begin
        if (!more && !pend_q) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_txn) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    count_d    = count_q;
    op_d       = op_q;
    key_d      = key_q;
    mask_d     = mask_q;
    status_d   = status_q;
    idx_d      = idx_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    mem_we     = 1'b0;
    mem_waddr  = hit_idx_q;
    mem_wdata  = '{key: key_q, mask: mask_q | ErrBit | HupBit};
    unique case (state_q)
      S_IDLE: begin
        if (in_txn) begin
          op_d     = op_e'(op_i);
          key_d    = key_fd_i;
          mask_d   = event_mask_i;
          status_d = ST_BADOP;
          idx_d    = '0;
        end
      end
      S_SEARCH: begin
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = pend_idx_q;
        end else if (more) begin
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IW-1:0];
          idx_d      = idx_q + 1'b1;
        end else if (!pend_q) begin
          hit_d = 1'b0;
        end
      end
      S_DECIDE: begin
        case (op_q)
          OP_ADD: begin
            if (hit_q) begin
              status_d = ST_EXISTS;
            end else if (full) begin
              status_d = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_q[IW-1:0];
              count_d   = count_q + 1'b1;
              status_d  = ST_OK;
            end
          end
          OP_DELETE: begin
            status_d = hit_q ? ST_OK : ST_MISSING;
            idx_d    = CW'(hit_idx_q) + 1'b1;
          end
          OP_MODIFY: begin
            if (hit_q) begin
              mem_we   = 1'b1;
              status_d = ST_OK;
            end else begin
              status_d = ST_MISSING;
            end
          end
          default: status_d = ST_BADOP;
        endcase
      end
      S_SHIFT: begin
        // read entry idx while writing the one fetched last cycle a place lower
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pend_idx_q - 1'b1;
          mem_wdata = rd_q;
        end
        if (more) begin
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IW-1:0];
          idx_d      = idx_q + 1'b1;
        end else if (!pend_q) begin
          count_d = count_q - 1'b1;
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    mask_q     <= mask_d;
    status_q   <= status_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[idx_q[IW-1:0]];
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1))
    else $error("entry count moved by more than one");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_OUT) |=> count_q == $past(count_q))
    else $error("entry count changed with no request at work");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_DECIDE || state_q == S_SHIFT))
    else $error("table written outside an update");

  a_exists_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_q == ST_EXISTS) |-> op_q == OP_ADD)
    else $error("already-exists status on a request other than add");
`endif

endmodule
